>>> hdl/cle_pkg.sv
// ----------------------------------------------------------------------------
// Cursor line editor package
// Shared constants, key codes and the command that drives the row of cells.
// ----------------------------------------------------------------------------
package cle_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int CAPACITY_MAX = 64;
   localparam int CNT_W        = $clog2(CAPACITY_MAX + 1);

   localparam logic [7:0] KEY_LEFT  = 8'h3C;
   localparam logic [7:0] KEY_RIGHT = 8'h3E;
   localparam logic [7:0] KEY_BACK  = 8'h2D;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic [CNT_W-1:0] pos;
      logic [7:0]       key;
   } cell_cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_FLUSH
   } state_type;

endpackage

>>> hdl/cle_cell.sv
// ----------------------------------------------------------------------------
// Cursor line editor cell
// Holds one character of the line and takes a neighbour's character when the
// text opens up for an insert or closes up after a delete or a flush transfer.
// ----------------------------------------------------------------------------
module cle_cell #(
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  cle_pkg::cell_cmd_type cmd,
   input  logic [7:0]            left_data,
   input  logic [7:0]            right_data,
   output logic [7:0]            data
);
   import cle_pkg::*;

   localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);

   logic [7:0] data_ff;
   logic [7:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (MY_POS == cmd.pos) begin
               data_in = cmd.key;
            end else if (MY_POS > cmd.pos) begin
               data_in = left_data;
            end
         end
         CELL_DELETE: begin
            if (MY_POS >= cmd.pos) begin
               data_in = right_data;
            end
         end
         CELL_SHIFT: begin
            data_in = right_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> hdl/cle_ctrl.sv
// ----------------------------------------------------------------------------
// Cursor line editor control
// Keeps the line length, cursor and overflow flag, decodes key strokes into
// cell commands and sequences the flush of the line.
// ----------------------------------------------------------------------------
module cle_ctrl #(
   parameter int CAPACITY = cle_pkg::CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_action,
   input  logic [7:0]            req_key,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_last,
   output logic                  rsp_empty,
   output logic                  rsp_overflow,
   output cle_pkg::cell_cmd_type cmd
);
   import cle_pkg::*;

   localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic             ovf_ff, ovf_in;
   logic             empty_ff, empty_in;
   logic             req_fire;
   logic             rsp_fire;

   assign req_fire = req_tvalid & req_tready;
   assign rsp_fire = rsp_tvalid & rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_action) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (rsp_fire && remain_ff == ONE) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_FLUSH: rsp_tvalid = 1'b1;
         default:  req_tready = 1'b0;
      endcase
   end

   assign rsp_last     = (remain_ff == ONE);
   assign rsp_empty    = empty_ff;
   assign rsp_overflow = ovf_ff;

   always_comb begin
      len_in    = len_ff;
      cur_in    = cur_ff;
      remain_in = remain_ff;
      ovf_in    = ovf_ff;
      empty_in  = empty_ff;
      cmd.op    = CELL_HOLD;
      cmd.pos   = cur_ff;
      cmd.key   = req_key;
      if (req_fire && !req_action) begin
         unique case (req_key)
            KEY_LEFT: begin
               if (cur_ff != '0) begin
                  cur_in = cur_ff - ONE;
               end
            end
            KEY_RIGHT: begin
               if (cur_ff != len_ff) begin
                  cur_in = cur_ff + ONE;
               end
            end
            KEY_BACK: begin
               if (cur_ff != '0) begin
                  cmd.op  = CELL_DELETE;
                  cmd.pos = cur_ff - ONE;
                  cur_in  = cur_ff - ONE;
                  len_in  = len_ff - ONE;
               end
            end
            default: begin
               if (len_ff >= CAP) begin
                  ovf_in = 1'b1;
               end else begin
                  cmd.op = CELL_INSERT;
                  cur_in = cur_ff + ONE;
                  len_in = len_ff + ONE;
               end
            end
         endcase
      end
      if (req_fire && req_action) begin
         empty_in  = (len_ff == '0);
         remain_in = (len_ff == '0) ? ONE : len_ff;
      end
      if (rsp_fire) begin
         cmd.op    = CELL_SHIFT;
         remain_in = remain_ff - ONE;
         if (remain_ff == ONE) begin
            len_in   = '0;
            cur_in   = '0;
            ovf_in   = 1'b0;
            empty_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         len_ff    <= '0;
         cur_ff    <= '0;
         remain_ff <= '0;
         ovf_ff    <= 1'b0;
         empty_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         len_ff    <= len_in;
         cur_ff    <= cur_in;
         remain_ff <= remain_in;
         ovf_ff    <= ovf_in;
         empty_ff  <= empty_in;
      end
   end

`ifndef ASSERT_OFF
   a_cursor_in_line: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= len_ff)
      else $error("cursor beyond end of line");

   a_len_in_capacity: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CAP)
      else $error("line length beyond capacity");

   a_flush_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> (remain_ff != '0))
      else $error("flush running with nothing left to send");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && remain_ff == ONE) |=> (len_ff == '0 && !ovf_ff && state_ff == ST_IDLE))
      else $error("line not cleared after final transfer");
`endif

endmodule

>>> hdl/cursor_line_editor_core.sv
// ----------------------------------------------------------------------------
// Cursor line editor core
// One-line text editor with a cursor, kept as a row of character cells.
// ----------------------------------------------------------------------------
//  Channel  Direction  tdata            tuser                    tlast
//  req_     in         key_code[7:0]    action                   -
//  rsp_     out        text_byte[7:0]   line_empty, overflowed   last_byte
//
//  A key stroke opens or closes the text in the cells on the edge that
//  takes it. An end-of-line transfer starts a flush of one result per
//  cycle while rsp_tready is high, len results in all (one for an empty
//  line), during which req_tready is low. The flush shifts the row of cells
//  towards cell 0. Reset is synchronous and clears the counts and the flag.
// ----------------------------------------------------------------------------
module cursor_line_editor_core #(
   parameter int CAPACITY = cle_pkg::CAPACITY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] key_code
   input  logic       req_tuser,   // [0] action
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] text_byte
   output logic [1:0] rsp_tuser,   // [0] line_empty, [1] overflowed
   output logic       rsp_tlast
);
   import cle_pkg::*;

   cell_cmd_type cmd;
   logic [7:0]   cell_data [CAPACITY];
   logic         rsp_empty;
   logic         rsp_overflow;

   cle_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_action   (req_tuser),
      .req_key      (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_last     (rsp_tlast),
      .rsp_empty    (rsp_empty),
      .rsp_overflow (rsp_overflow),
      .cmd          (cmd)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [7:0] left_data;
      logic [7:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = 8'h00;
      end else begin : g_mid_left
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = 8'h00;
      end else begin : g_mid_right
         assign right_data = cell_data[i+1];
      end

      cle_cell #(
         .INDEX(i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i])
      );
   end

   assign rsp_tdata = rsp_empty ? 8'h00 : cell_data[0];
   assign rsp_tuser = {rsp_overflow, rsp_empty};

endmodule
